/* hw/rtl/async_frame_receiver_ring_core_defines.svh */
// Assertion macros shared by the checker of the frame receiver ring core.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASYNC_FRAME_RECEIVER_RING_CORE_DEFINES_SVH
`define ASYNC_FRAME_RECEIVER_RING_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFRR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/afrr_pkg.sv */
// Package of the frame receiver ring core: event codes, register indexes,
// constants and the transaction structs. Depends on nothing.
`default_nettype none

package afrr_pkg;

    localparam int unsigned RING_DEPTH_DEF    = 16;
    localparam int unsigned START_BIT_POS_DEF = 31;

    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    localparam logic [1:0] CFG_ADDR_MASK  = 2'd0;
    localparam logic [1:0] CFG_STRIP_MASK = 2'd1;
    localparam logic [1:0] CFG_SEND_MASK  = 2'd2;

    localparam logic [31:0] LOW_ONES      = 32'h0000_3fff;
    localparam logic [4:0]  LAST_DATA_POS = 5'd14;
    localparam logic [7:0]  ERROR_LIMIT   = 8'd250;

    typedef struct packed {
        logic [1:0] op;
        logic       line_level;
    } item_t;

    typedef struct packed {
        logic [31:0] pop_word;
        logic        has_words;
        logic        frame_done;
        logic [31:0] captured_word;
        logic        frame_error;
        logic [7:0]  framing_errors;
        logic [31:0] overruns;
        logic        send_changed;
        logic        send_level;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [31:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic        wr;
        logic [31:0] data;
    } ring_wr_t;

    typedef struct packed {
        logic        frame_done;
        logic [31:0] captured_word;
        logic        frame_error;
        logic [7:0]  framing_errors;
        logic        send_changed;
        logic        send_level;
    } rx_status_t;

    typedef struct packed {
        logic [31:0] pop_word;
        logic        has_words;
        logic [31:0] overruns;
    } ring_status_t;

endpackage

`default_nettype wire

/* hw/rtl/afrr_rx.sv */
// Serial frame receiver: start check, MSB-first shifting, error count,
// address match, strip and send level tracking. Depends on afrr_pkg.
`default_nettype none

module afrr_rx #(
    parameter int unsigned START_BIT_POS = afrr_pkg::START_BIT_POS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  afrr_pkg::cfg_wr_t    cfg_wr,
    input  logic                 step,
    input  afrr_pkg::item_t      item,
    output afrr_pkg::ring_wr_t   ring_wr,
    output afrr_pkg::rx_status_t status
);
    import afrr_pkg::*;

    localparam logic [4:0] START_POS = 5'(START_BIT_POS);

    logic [31:0] addr_mask_reg;
    logic [31:0] strip_mask_reg;
    logic [31:0] send_mask_reg;
    logic [31:0] shift_word_reg, shift_word_next;
    logic [4:0]  bit_pos_reg, bit_pos_next;
    logic        receiving_reg, receiving_next;
    logic [7:0]  error_count_reg, error_count_next;
    logic        last_send_reg, last_send_next;
    logic        send_known_reg, send_known_next;
    logic [31:0] shift_set;
    logic [31:0] done_word;
    logic        send_bit;

    always_comb
    begin
        shift_set = shift_word_reg;
        if (item.line_level)
        begin
            shift_set[bit_pos_reg] = 1'b1;
        end
        done_word = shift_set | LOW_ONES;
        send_bit  = |(done_word & send_mask_reg);

        shift_word_next  = shift_word_reg;
        bit_pos_next     = bit_pos_reg;
        receiving_next   = receiving_reg;
        error_count_next = error_count_reg;
        last_send_next   = last_send_reg;
        send_known_next  = send_known_reg;
        ring_wr          = '0;
        status           = '0;

        if (step)
        begin
            case (item.op)
                OP_EDGE:
                begin
                    if (!receiving_reg)
                    begin
                        receiving_next  = 1'b1;
                        shift_word_next = '0;
                        bit_pos_next    = START_POS;
                    end
                end
                OP_SAMPLE:
                begin
                    if (receiving_reg)
                    begin
                        if (bit_pos_reg == START_POS)
                        begin
                            if (item.line_level)
                            begin
                                status.frame_error = 1'b1;
                                receiving_next     = 1'b0;
                                if (error_count_reg < ERROR_LIMIT)
                                begin
                                    error_count_next = error_count_reg + 8'd1;
                                end
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg - 5'd1;
                            end
                        end
                        else
                        begin
                            shift_word_next = shift_set;
                            bit_pos_next    = bit_pos_reg - 5'd1;
                            if (bit_pos_reg == LAST_DATA_POS)
                            begin
                                receiving_next       = 1'b0;
                                status.frame_done    = 1'b1;
                                status.captured_word = done_word;
                                ring_wr.wr           = 1'b1;
                                ring_wr.data         = done_word;
                                if ((done_word & addr_mask_reg) != '0)
                                begin
                                    ring_wr.data = done_word & ~strip_mask_reg;
                                    if (!send_known_reg || (send_bit != last_send_reg))
                                    begin
                                        send_known_next     = 1'b1;
                                        last_send_next      = send_bit;
                                        status.send_changed = 1'b1;
                                        status.send_level   = send_bit;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_FLUSH:
                begin
                    receiving_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        status.framing_errors = error_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_mask_reg   <= '0;
            strip_mask_reg  <= '0;
            send_mask_reg   <= '0;
            shift_word_reg  <= '0;
            bit_pos_reg     <= '0;
            receiving_reg   <= 1'b0;
            error_count_reg <= '0;
            last_send_reg   <= 1'b0;
            send_known_reg  <= 1'b0;
        end
        else
        begin
            shift_word_reg  <= shift_word_next;
            bit_pos_reg     <= bit_pos_next;
            receiving_reg   <= receiving_next;
            error_count_reg <= error_count_next;
            last_send_reg   <= last_send_next;
            send_known_reg  <= send_known_next;
            if (cfg_wr.valid)
            begin
                case (cfg_wr.index)
                    CFG_ADDR_MASK:  addr_mask_reg  <= cfg_wr.data;
                    CFG_STRIP_MASK: strip_mask_reg <= cfg_wr.data;
                    CFG_SEND_MASK:  send_mask_reg  <= cfg_wr.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/afrr_ring.sv */
// Ring of received words with head and tail indexes and an overrun counter.
// Depends on afrr_pkg.
`default_nettype none

module afrr_ring #(
    parameter int unsigned RING_DEPTH = afrr_pkg::RING_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  afrr_pkg::item_t        item,
    input  afrr_pkg::ring_wr_t     ring_wr,
    output afrr_pkg::ring_status_t status
);
    import afrr_pkg::*;

    localparam int unsigned IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

    logic [31:0]   ring_store [RING_DEPTH];
    logic [31:0]   tail_word_reg;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [31:0]   overrun_reg, overrun_next;
    logic          write_en;

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] v);
        logic [IW-1:0] r;
        if (v == LAST_IDX)
        begin
            r = '0;
        end
        else
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    assign write_en = step && ring_wr.wr;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        overrun_next    = overrun_reg;
        status.pop_word = '0;

        if (write_en)
        begin
            head_next = inc_idx(head_reg);
            if (head_next == tail_reg)
            begin
                overrun_next = overrun_reg + 32'd1;
            end
        end
        else if (step)
        begin
            case (item.op)
                OP_POP:
                begin
                    if (head_reg != tail_reg)
                    begin
                        status.pop_word = tail_word_reg;
                        tail_next       = inc_idx(tail_reg);
                    end
                end
                OP_FLUSH:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        status.has_words = (head_next != tail_next);
        status.overruns  = overrun_next;
    end

    // The word at the next tail is fetched into a register ahead of the pop; a write into that
    // slot is forwarded.
    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            ring_store[head_reg] <= ring_wr.data;
        end
        if (write_en && (head_reg == tail_next))
        begin
            tail_word_reg <= ring_wr.data;
        end
        else
        begin
            tail_word_reg <= ring_store[tail_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            overrun_reg <= '0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            overrun_reg <= overrun_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/async_frame_receiver_ring_core.sv */
// Top level of the frame receiver ring core: input register, receiver,
// ring and result register. Depends on afrr_pkg, afrr_rx and afrr_ring.
//
//  Channel   Direction  Handshake                 Payload
//  item      in         item_valid / item_stall   afrr_pkg::item_t
//  result    out        result_valid / result_stall afrr_pkg::result_t
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Every event yields one result transaction, through input and result register.
// A new event is accepted in every cycle while results are being taken; the
// path from the input register through receiver and ring to the result
// register sets that figure. When the result register is held by result_stall
// and the input register is full, item_stall rises. Reset clears all counters,
// indexes and masks; the ring contents need no clearing.
`default_nettype none

module async_frame_receiver_ring_core #(
    parameter int unsigned RING_DEPTH    = afrr_pkg::RING_DEPTH_DEF,
    parameter int unsigned START_BIT_POS = afrr_pkg::START_BIT_POS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  afrr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output afrr_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import afrr_pkg::*;

    logic         in_valid_reg;
    item_t        in_item_reg;
    logic         out_valid_reg;
    result_t      out_item_reg;
    result_t      out_item_next;
    logic         advance;
    logic         step;
    cfg_wr_t      cfg_wr;
    ring_wr_t     ring_wr;
    rx_status_t   rx_status;
    ring_status_t ring_status;

    assign advance    = !out_valid_reg || !result_stall;
    assign step       = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;
    assign cfg_ready  = 1'b1;

    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    afrr_rx #(
        .START_BIT_POS(START_BIT_POS)
    ) u_rx (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .step    (step),
        .item    (in_item_reg),
        .ring_wr (ring_wr),
        .status  (rx_status)
    );

    afrr_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .item    (in_item_reg),
        .ring_wr (ring_wr),
        .status  (ring_status)
    );

    always_comb
    begin
        out_item_next.pop_word       = ring_status.pop_word;
        out_item_next.has_words      = ring_status.has_words;
        out_item_next.frame_done     = rx_status.frame_done;
        out_item_next.captured_word  = rx_status.captured_word;
        out_item_next.frame_error    = rx_status.frame_error;
        out_item_next.framing_errors = rx_status.framing_errors;
        out_item_next.overruns       = ring_status.overruns;
        out_item_next.send_changed   = rx_status.send_changed;
        out_item_next.send_level     = rx_status.send_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
        if (step)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

/* hw/rtl/afrr_checker.sv */
// Port-level checker of the frame receiver ring core and its bind statement.
// Depends on afrr_pkg and async_frame_receiver_ring_core_defines.svh.
`default_nettype none

`include "async_frame_receiver_ring_core_defines.svh"

module afrr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input afrr_pkg::result_t result
);
    import afrr_pkg::*;

    `AFRR_ASSERT_NOW(a_err_limit, clk, rst_n, result_valid, result.framing_errors <= ERROR_LIMIT, "framing error count above limit")
    `AFRR_ASSERT_NOW(a_done_xor_err, clk, rst_n, result_valid, !(result.frame_done && result.frame_error), "frame done and framing error in one transaction")
    `AFRR_ASSERT_NOW(a_low_ones, clk, rst_n, result_valid && result.frame_done, result.captured_word[13:0] == 14'h3fff, "captured word low bits not set")
    `AFRR_ASSERT_NOW(a_level_quiet, clk, rst_n, result_valid && !result.send_changed, !result.send_level, "send level without change")
    `AFRR_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result transaction changed")

endmodule

bind async_frame_receiver_ring_core afrr_checker u_afrr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

/* tb/async_frame_receiver_ring_core_test.sv */
// Self-checking testbench for async_frame_receiver_ring_core: drives event and register
// transactions, predicts every result transaction and compares them field by field.
// Depends on afrr_pkg and async_frame_receiver_ring_core.
module async_frame_receiver_ring_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import afrr_pkg::*;

    localparam int          PTR_W          = $clog2(RING_DEPTH_DEF);
    localparam logic [31:0] START_BIT      = 32'h1 << START_BIT_POS_DEF;
    localparam logic [31:0] DONE_BIT       = 32'h1 << (LAST_DATA_POS - 5'd1);
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic        item_stall;
    item_t       item         = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = '0;
    logic [31:0] cfg_data     = '0;

    // Predicted receiver and ring state.
    logic [31:0] addr_mask_m;
    logic [31:0] strip_mask_m;
    logic [31:0] send_mask_m;
    logic [31:0] rx_word;
    logic [31:0] rx_bit;
    logic        rx_busy;
    logic [31:0] ring_mem [RING_DEPTH_DEF];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic [7:0]  err_cnt;
    logic [31:0] ovr_cnt;
    logic        send_last;
    logic        send_seen;

    result_t     pending_results [$];
    result_t     want_result;
    bit          quiet = 1'b0;
    int unsigned fail_count = 0;
    int unsigned events_sent = 0;
    int unsigned results_seen = 0;
    int unsigned frames_stored = 0;
    int unsigned start_errors = 0;
    int unsigned send_changes = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned stall_len;

    async_frame_receiver_ring_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_data();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic result_t predict_event(input item_t pkt);
        result_t     r;
        logic [31:0] word;
        logic [31:0] kept;
        logic        level;
        r = '0;
        case (pkt.op)
            OP_EDGE:
            begin
                if (!rx_busy)
                begin
                    rx_busy = 1'b1;
                    rx_word = '0;
                    rx_bit  = START_BIT;
                end
            end
            OP_SAMPLE:
            begin
                if (rx_busy && rx_bit == START_BIT)
                begin
                    if (pkt.line_level)
                    begin
                        r.frame_error = 1'b1;
                        start_errors++;
                        rx_busy = 1'b0;
                        if (err_cnt < ERROR_LIMIT)
                            err_cnt++;
                    end
                    else
                        rx_bit = rx_bit >> 1;
                end
                else if (rx_busy)
                begin
                    if (pkt.line_level)
                        rx_word = rx_word | rx_bit;
                    rx_bit = rx_bit >> 1;
                    if (rx_bit == DONE_BIT || rx_bit == '0)
                    begin
                        word = rx_word | LOW_ONES;
                        kept = word;
                        r.frame_done    = 1'b1;
                        r.captured_word = word;
                        if ((word & addr_mask_m) != '0)
                        begin
                            level = (word & send_mask_m) != '0;
                            kept  = word & ~strip_mask_m;
                            if (!send_seen || level != send_last)
                            begin
                                send_seen      = 1'b1;
                                send_last      = level;
                                r.send_changed = 1'b1;
                                r.send_level   = level;
                                send_changes++;
                            end
                        end
                        ring_mem[wr_ptr] = kept;
                        wr_ptr = wr_ptr + 1'b1;
                        if (wr_ptr == rd_ptr)
                            ovr_cnt++;
                        rx_busy = 1'b0;
                        frames_stored++;
                    end
                end
            end
            OP_POP:
            begin
                if (wr_ptr != rd_ptr)
                begin
                    r.pop_word = ring_mem[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                end
            end
            OP_FLUSH:
            begin
                wr_ptr  = '0;
                rd_ptr  = '0;
                rx_busy = 1'b0;
            end
        endcase
        r.has_words      = wr_ptr != rd_ptr;
        r.framing_errors = err_cnt;
        r.overruns       = ovr_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Each accepted result transaction is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual %h", $time, result);
                fail_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("pop_word", want_result.pop_word, result.pop_word);
                check_field("has_words", 32'(want_result.has_words),
                            32'(result.has_words));
                check_field("frame_done", 32'(want_result.frame_done),
                            32'(result.frame_done));
                check_field("captured_word", want_result.captured_word,
                            result.captured_word);
                check_field("frame_error", 32'(want_result.frame_error),
                            32'(result.frame_error));
                check_field("framing_errors", 32'(want_result.framing_errors),
                            32'(result.framing_errors));
                check_field("overruns", want_result.overruns, result.overruns);
                check_field("send_changed", 32'(want_result.send_changed),
                            32'(result.send_changed));
                check_field("send_level", 32'(want_result.send_level),
                            32'(result.send_level));
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left--;
        else
        begin
            stall_len = pick_pause();
            if (stall_len == 0)
            begin
                result_stall <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
            begin
                result_stall <= 1'b1;
                stall_left = stall_len - 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
            $display("** async_frame_receiver_ring_core: FAILED **");
            $finish;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic line);
        item_t       pkt;
        int unsigned pause;
        pkt.op         = op;
        pkt.line_level = line;
        item       <= pkt;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(predict_event(pkt));
        events_sent++;
        pause = pick_pause();
        if (pause != 0)
        begin
            item_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ADDR_MASK:  addr_mask_m  = value;
            CFG_STRIP_MASK: strip_mask_m = value;
            CFG_SEND_MASK:  send_mask_m  = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] addr_m, input logic [31:0] strip_m,
                             input logic [31:0] send_m);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(CFG_ADDR_MASK, addr_m);
        write_reg(CFG_STRIP_MASK, strip_m);
        write_reg(CFG_SEND_MASK, send_m);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input logic [31:0] data, input bit noisy);
        int k;
        send_event(OP_EDGE, 1'($urandom_range(0, 1)));
        send_event(OP_SAMPLE, 1'b0);
        for (k = START_BIT_POS_DEF - 1; k >= int'(LAST_DATA_POS); k--)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_event($urandom_range(0, 1) ? OP_EDGE : OP_POP,
                           1'($urandom_range(0, 1)));
            send_event(OP_SAMPLE, data[k]);
        end
    endtask

    task automatic test_special_cases();
        send_event(OP_POP, 1'b1);
        send_event(OP_SAMPLE, 1'b1);
        send_event(OP_SAMPLE, 1'b0);
        send_event(OP_FLUSH, 1'b0);
        send_event(OP_EDGE, 1'b0);
        send_event(OP_EDGE, 1'b1);
        send_event(OP_SAMPLE, 1'b1);
        send_event(OP_SAMPLE, 1'b1);
        send_event(OP_EDGE, 1'b1);
        send_event(OP_SAMPLE, 1'b0);
        send_event(OP_SAMPLE, 1'b1);
        send_event(OP_FLUSH, 1'b1);
        send_event(OP_SAMPLE, 1'b0);
        send_event(OP_POP, 1'b0);
    endtask

    task automatic test_error_saturation();
        int          n;
        int unsigned r;
        for (n = 0; n < 260; n++)
        begin
            r = $urandom_range(0, 31);
            if (r == 0)
                send_frame(pick_data(), 1'b0);
            else if (r == 1)
                send_event(OP_POP, 1'($urandom_range(0, 1)));
            send_event(OP_EDGE, 1'($urandom_range(0, 1)));
            send_event(OP_SAMPLE, 1'b1);
        end
    endtask

    task automatic test_overrun();
        int n;
        quiet = 1'b1;
        for (n = 0; n < 20; n++)
            send_frame(pick_data(), 1'b0);
        quiet = 1'b0;
        for (n = 0; n < 22; n++)
            send_event(OP_POP, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned stop_at;
        int unsigned r;
        stop_at = events_sent + count;
        while (events_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                quiet = ~quiet;
            if (r < 55)
                send_frame(pick_data(), r < 15);
            else if (r < 65)
            begin
                send_event(OP_EDGE, 1'($urandom_range(0, 1)));
                send_event(OP_SAMPLE, 1'b1);
            end
            else if (r < 88)
                repeat ($urandom_range(1, 4)) send_event(OP_POP, 1'($urandom_range(0, 1)));
            else if (r < 91)
                send_event(OP_FLUSH, 1'($urandom_range(0, 1)));
            else if (r < 98)
                send_event(OP_SAMPLE, 1'($urandom_range(0, 1)));
            else
                wait_drained();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        addr_mask_m  = '0;
        strip_mask_m = '0;
        send_mask_m  = '0;
        rx_word      = '0;
        rx_bit       = '0;
        rx_busy      = 1'b0;
        wr_ptr       = '0;
        rd_ptr       = '0;
        err_cnt      = '0;
        ovr_cnt      = '0;
        send_last    = 1'b0;
        send_seen    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure('0, '0, '0);
        test_special_cases();
        test_error_saturation();
        configure('1, $urandom, 32'h1 << $urandom_range(14, 30));
        test_random_traffic(150);
        configure(32'h1 << $urandom_range(14, 30), '1, '1);
        test_overrun();
        test_random_traffic(150);
        configure($urandom, $urandom, $urandom);
        test_random_traffic(150);
        configure('1, '0, 32'h1 << 30);
        test_random_traffic(150);

        wait_drained();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            fail_count++;
        end
        $display("Sent %0d events and checked %0d results under five mask settings.",
                 events_sent, results_seen);
        $display("Saw %0d stored frames, %0d start-bit errors, %0d overruns, %0d send changes.",
                 frames_stored, start_errors, ovr_cnt, send_changes);
        if (fail_count == 0)
            $display("** async_frame_receiver_ring_core: PASSED **");
        else
            $display("** async_frame_receiver_ring_core: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/afrr_pkg.sv
hw/rtl/afrr_rx.sv
hw/rtl/afrr_ring.sv
hw/rtl/async_frame_receiver_ring_core.sv
hw/rtl/afrr_checker.sv
tb/async_frame_receiver_ring_core_test.sv
